/* rtl/ocpl_pkg.sv */
// Shared types, constants and codes for the octree point occupancy lookup unit.
// Used by every module of the block except ocpl_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ocpl_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int MAX_LEVELS  = 8;

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int IDX_W   = ADDR_W + 1;
   localparam int LEVEL_W = $clog2(MAX_LEVELS + 1);
   localparam int DATA_W  = 32;
   localparam int BAND_W  = 31;
   localparam int MASK_W  = 8;
   localparam int OCT_W   = 3;
   localparam int CNT_W   = 3;
   localparam int CSR_W   = 3;

   localparam logic [IDX_W-1:0]   TABLE_LIMIT = IDX_W'(TABLE_DEPTH);
   localparam logic [LEVEL_W-1:0] LEVEL_CAP   = LEVEL_W'(MAX_LEVELS);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] OCC_EMPTY   = 2'd0;
   localparam logic [1:0] OCC_SURFACE = 2'd1;
   localparam logic [1:0] OCC_INSIDE  = 2'd2;

   localparam logic [DATA_W-1:0] DIST_NOT_FOUND = 32'h7FFF_FFFF;

   localparam logic [CSR_W-1:0] CSR_MIN_X = 3'd0;
   localparam logic [CSR_W-1:0] CSR_MIN_Y = 3'd1;
   localparam logic [CSR_W-1:0] CSR_MIN_Z = 3'd2;
   localparam logic [CSR_W-1:0] CSR_MAX_X = 3'd3;
   localparam logic [CSR_W-1:0] CSR_MAX_Y = 3'd4;
   localparam logic [CSR_W-1:0] CSR_MAX_Z = 3'd5;
   localparam logic [CSR_W-1:0] CSR_BAND  = 3'd6;
   localparam logic [CSR_W-1:0] CSR_NODES = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] min_dist;
      logic [DATA_W-1:0] max_dist;
      logic [MASK_W-1:0] mask;
      logic [ADDR_W-1:0] first_child;
   } node_entry_type;

   localparam int ENTRY_W = $bits(node_entry_type);

   typedef struct packed {
      logic [2:0][DATA_W-1:0] bound_min;
      logic [2:0][DATA_W-1:0] bound_max;
      logic [BAND_W-1:0]      band;
      logic [IDX_W-1:0]       nodes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      bound_min: '{32'd0, 32'd0, 32'd0},
      bound_max: '{32'd65536, 32'd65536, 32'd65536},
      band:      '0,
      nodes:     '0
   };

   typedef struct packed {
      logic              hit_valid;
      logic [ADDR_W-1:0] hit_node;
      logic [1:0]        occupancy;
      logic [DATA_W-1:0] distance_guess;
   } result_type;

endpackage

`default_nettype wire

/* rtl/ocpl_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ocpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/ocpl_classify.sv */
// Builds one result word from a located node's distances or from a miss.
// Depends on ocpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocpl_classify
   import ocpl_pkg::*;
(
   input  wire logic              found,
   input  wire logic [ADDR_W-1:0] node,
   input  wire logic [DATA_W-1:0] min_dist,
   input  wire logic [DATA_W-1:0] max_dist,
   input  wire logic [BAND_W-1:0] band,
   output result_type             result
);

   logic signed [DATA_W:0] band_pos;
   logic signed [DATA_W:0] band_neg;
   logic signed [DATA_W:0] mn_ext;
   logic signed [DATA_W:0] mx_ext;
   logic        [DATA_W:0] dist_sum;
   logic        [1:0]      occ;

   always_comb begin
      band_pos = $signed({2'b00, band});
      band_neg = -band_pos;
      mn_ext   = $signed({min_dist[DATA_W-1], min_dist});
      mx_ext   = $signed({max_dist[DATA_W-1], max_dist});
      dist_sum = $unsigned(mn_ext + mx_ext);
      priority if (mx_ext < band_neg) begin
         occ = OCC_INSIDE;
      end else if (mn_ext > band_pos) begin
         occ = OCC_EMPTY;
      end else begin
         occ = OCC_SURFACE;
      end
      if (found) begin
         result.hit_valid      = 1'b1;
         result.hit_node       = node;
         result.occupancy      = occ;
         result.distance_guess = dist_sum[DATA_W:1];
      end else begin
         result.hit_valid      = 1'b0;
         result.hit_node       = '0;
         result.occupancy      = OCC_EMPTY;
         result.distance_guess = DIST_NOT_FOUND;
      end
   end

endmodule

`default_nettype wire

/* rtl/ocpl_walker.sv */
// Query sequencer: descends the node table one level per read, tracking the box.
// Depends on ocpl_pkg and ocpl_classify; reads the table through the top level RAM.
`timescale 1ns / 1ps
`default_nettype none

module ocpl_walker
   import ocpl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   query_start,
   input  wire logic [2:0][DATA_W-1:0] point,
   input  wire cfg_type                cfg,
   output logic                        rd_en,
   output logic        [ADDR_W-1:0]    rd_addr,
   input  wire node_entry_type         rd_entry,
   output logic                        busy,
   output logic                        rsp_valid,
   output result_type                  rsp
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADDR = 2'd1;
   localparam logic [1:0] S_DATA = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [OCT_W-1:0]   oct_ff, oct_in;
   logic signed [DATA_W-1:0] lo_ff [3];
   logic signed [DATA_W-1:0] lo_in [3];
   logic signed [DATA_W-1:0] hi_ff [3];
   logic signed [DATA_W-1:0] hi_in [3];
   logic signed [DATA_W-1:0] pt_ff [3];
   logic signed [DATA_W-1:0] pt_in [3];
   logic signed [DATA_W-1:0] ctr_ff [3];
   logic signed [DATA_W-1:0] ctr_in [3];
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               out_of_range;
   logic               leaf_found;
   logic               done_found;
   logic [CNT_W-1:0]   below_cnt;
   logic [DATA_W:0]    box_sum;
   result_type         cls_result;

   assign out_of_range = (idx_ff >= cfg.nodes) || (idx_ff >= TABLE_LIMIT);
   assign leaf_found   = (rd_entry.mask == '0) || (level_ff == LEVEL_CAP)
                         || !rd_entry.mask[oct_ff];
   assign done_found   = (state_ff == S_DATA) && leaf_found;

   assign rd_en   = (state_ff == S_ADDR) && !out_of_range;
   assign rd_addr = idx_ff[ADDR_W-1:0];
   assign busy    = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   ocpl_classify u_classify (
      .found    (done_found),
      .node     (idx_ff[ADDR_W-1:0]),
      .min_dist (rd_entry.min_dist),
      .max_dist (rd_entry.max_dist),
      .band     (cfg.band),
      .result   (cls_result)
   );

   always_comb begin
      below_cnt = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if ((OCT_W'(i) < oct_ff) && rd_entry.mask[i]) begin
            below_cnt = below_cnt + CNT_W'(1);
         end
      end
   end

   always_comb begin
      box_sum      = '0;
      state_in     = state_ff;
      idx_in       = idx_ff;
      level_in     = level_ff;
      oct_in       = oct_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pt_in        = pt_ff;
      ctr_in       = ctr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (query_start) begin
               for (int a = 0; a < 3; a++) begin
                  lo_in[a] = $signed(cfg.bound_min[a]);
                  hi_in[a] = $signed(cfg.bound_max[a]);
                  pt_in[a] = $signed(point[a]);
               end
               idx_in   = '0;
               level_in = '0;
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            for (int a = 0; a < 3; a++) begin
               box_sum   = $unsigned({lo_ff[a][DATA_W-1], lo_ff[a]})
                           + $unsigned({hi_ff[a][DATA_W-1], hi_ff[a]});
               ctr_in[a] = $signed(box_sum[DATA_W:1]);
               oct_in[a] = (pt_ff[a] >= ctr_in[a]);
            end
            if (out_of_range) begin
               rsp_valid_in = 1'b1;
               rsp_in       = cls_result;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            if (leaf_found) begin
               rsp_valid_in = 1'b1;
               rsp_in       = cls_result;
               state_in     = S_IDLE;
            end else begin
               for (int a = 0; a < 3; a++) begin
                  if (oct_ff[a]) begin
                     lo_in[a] = ctr_ff[a];
                  end else begin
                     hi_in[a] = ctr_ff[a];
                  end
               end
               idx_in   = {1'b0, rd_entry.first_child} + IDX_W'(below_cnt);
               level_in = level_ff + LEVEL_W'(1);
               state_in = S_ADDR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      level_ff <= level_in;
      oct_ff   <= oct_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pt_ff    <= pt_in;
      ctr_ff   <= ctr_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

/* rtl/octree_point_occupancy_lookup_unit.sv */
// Top level of the octree point occupancy lookup unit: registers, node table, walker.
// Depends on ocpl_pkg, ocpl_ram and ocpl_walker.
//
// Use: a word is offered on the req_ ports with start high and is taken at an edge
// where busy is low. A write word (operation 0) stores one node entry in the table
// at that edge and produces no response; busy stays low, so writes can follow
// back to back. A query word (operation 1) raises busy and walks the tree from
// node 0; for each node visited, the address state presents the table address and
// computes the box centers; the data state takes the entry and chooses the child.
// The response appears on the rsp_ ports for one cycle with rsp_valid high,
// after at most nine nodes are read; the walk also ends, with no table read, when
// the root index or a child index is out of range. Busy drops in the same cycle,
// so the next word may be taken while the response shows.
// The receiver cannot stall; every response must be taken when strobed.
// Control registers are written on the csr_ port, which is always ready; they
// should change only while busy is low. Reset clears the registers to their
// defaults and aborts any walk; the node table keeps no reset value and must be
// written before a query can reach an entry.
`timescale 1ns / 1ps
`default_nettype none

module octree_point_occupancy_lookup_unit
   import ocpl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_operation,
   input  wire logic [ADDR_W-1:0] req_node_slot,
   input  wire logic [DATA_W-1:0] req_entry_min_dist,
   input  wire logic [DATA_W-1:0] req_entry_max_dist,
   input  wire logic [MASK_W-1:0] req_entry_mask,
   input  wire logic [ADDR_W-1:0] req_entry_first_child,
   input  wire logic [DATA_W-1:0] req_point_x,
   input  wire logic [DATA_W-1:0] req_point_y,
   input  wire logic [DATA_W-1:0] req_point_z,
   output logic                   rsp_valid,
   output logic                   rsp_hit_valid,
   output logic      [ADDR_W-1:0] rsp_hit_node,
   output logic      [1:0]        rsp_occupancy,
   output logic      [DATA_W-1:0] rsp_distance_guess,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0] csr_data
);

   cfg_type        cfg_ff, cfg_in;
   logic           accept;
   logic           wr_en;
   node_entry_type wr_entry;
   logic           rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   result_type     rsp;
   logic [2:0][DATA_W-1:0] point;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign wr_en     = accept && (req_operation == OP_WRITE);

   assign wr_entry.min_dist    = req_entry_min_dist;
   assign wr_entry.max_dist    = req_entry_max_dist;
   assign wr_entry.mask        = req_entry_mask;
   assign wr_entry.first_child = req_entry_first_child;

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_X: cfg_in.bound_min[0] = csr_data;
            CSR_MIN_Y: cfg_in.bound_min[1] = csr_data;
            CSR_MIN_Z: cfg_in.bound_min[2] = csr_data;
            CSR_MAX_X: cfg_in.bound_max[0] = csr_data;
            CSR_MAX_Y: cfg_in.bound_max[1] = csr_data;
            CSR_MAX_Z: cfg_in.bound_max[2] = csr_data;
            CSR_BAND:  cfg_in.band         = csr_data[BAND_W-1:0];
            CSR_NODES: cfg_in.nodes        = csr_data[IDX_W-1:0];
            default:   cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ocpl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_node_slot),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ocpl_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .query_start (accept && (req_operation == OP_QUERY)),
      .point       (point),
      .cfg         (cfg_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_entry    (node_entry_type'(rd_data)),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign rsp_hit_valid      = rsp.hit_valid;
   assign rsp_hit_node       = rsp.hit_node;
   assign rsp_occupancy      = rsp.occupancy;
   assign rsp_distance_guess = rsp.distance_guess;

endmodule

`default_nettype wire

/* test/tb_octree_point_occupancy_lookup_unit.sv */
// Self-checking testbench for octree_point_occupancy_lookup_unit: node table writes and
// point queries over several register settings, checked against a mirror of the table.
// Depends on ocpl_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_octree_point_occupancy_lookup_unit;
   import ocpl_pkg::*;

   typedef struct {
      bit                     op;
      bit [ADDR_W-1:0]        slot;
      bit [DATA_W-1:0]        min_d;
      bit [DATA_W-1:0]        max_d;
      bit [MASK_W-1:0]        mask;
      bit [ADDR_W-1:0]        child;
      bit [2:0][DATA_W-1:0]   point;
   } lookup_word_type;

   class lookup_mirror;
      bit [DATA_W-1:0] bound_lo [3];
      bit [DATA_W-1:0] bound_hi [3];
      bit [BAND_W-1:0] band;
      bit [12:0]       node_count;
      bit [DATA_W-1:0] min_dist [TABLE_DEPTH];
      bit [DATA_W-1:0] max_dist [TABLE_DEPTH];
      bit [MASK_W-1:0] child_mask [TABLE_DEPTH];
      bit [ADDR_W-1:0] first_child [TABLE_DEPTH];
      bit              loaded [TABLE_DEPTH];
      result_type      hits_due [$];
      int              errors, writes, queries, misses;
      int              class_seen [3];

      function new();
         for (int a = 0; a < 3; a++) begin
            bound_lo[a] = 0;
            bound_hi[a] = 65536;
         end
         band = 0;
         node_count = 0;
      endfunction

      function void set_reg(bit [CSR_W-1:0] index, bit [DATA_W-1:0] data);
         case (index)
            CSR_MIN_X: bound_lo[0] = data;
            CSR_MIN_Y: bound_lo[1] = data;
            CSR_MIN_Z: bound_lo[2] = data;
            CSR_MAX_X: bound_hi[0] = data;
            CSR_MAX_Y: bound_hi[1] = data;
            CSR_MAX_Z: bound_hi[2] = data;
            CSR_BAND:  band = data[BAND_W-1:0];
            CSR_NODES: node_count = data[12:0];
            default: ;
         endcase
      endfunction

      // Walks the mirrored tree; the return value is low if any entry read was never written.
      function bit locate(bit [2:0][DATA_W-1:0] point, output result_type hit);
         longint lo [3];
         longint hi [3];
         longint pt [3];
         longint ctr [3];
         longint mn, mx, bandv, mid;
         int     idx, limit, m, oct;
         bit     found, clean;
         idx = 0;
         found = 0;
         clean = 1;
         for (int a = 0; a < 3; a++) begin
            lo[a] = $signed(bound_lo[a]);
            hi[a] = $signed(bound_hi[a]);
            pt[a] = $signed(point[a]);
         end
         limit = (node_count > TABLE_DEPTH) ? TABLE_DEPTH : node_count;
         for (int level = 0; level <= MAX_LEVELS; level++) begin
            if (idx >= limit) break;
            if (!loaded[idx]) clean = 0;
            m = child_mask[idx];
            if (m == 0 || level == MAX_LEVELS) begin
               found = 1;
               break;
            end
            oct = 0;
            for (int a = 0; a < 3; a++) begin
               ctr[a] = (lo[a] + hi[a]) >>> 1;
               if (pt[a] >= ctr[a]) oct |= 1 << a;
            end
            if (!m[oct]) begin
               found = 1;
               break;
            end
            for (int a = 0; a < 3; a++) begin
               if (oct[a]) lo[a] = ctr[a];
               else hi[a] = ctr[a];
            end
            idx = first_child[idx] + $countones(m & ((1 << oct) - 1));
         end
         if (found) begin
            mn = $signed(min_dist[idx]);
            mx = $signed(max_dist[idx]);
            bandv = band;
            mid = (mn + mx) >>> 1;
            hit.hit_valid = 1'b1;
            hit.hit_node = idx[ADDR_W-1:0];
            if (mx < -bandv) hit.occupancy = OCC_INSIDE;
            else if (mn > bandv) hit.occupancy = OCC_EMPTY;
            else hit.occupancy = OCC_SURFACE;
            hit.distance_guess = mid[DATA_W-1:0];
         end else begin
            hit.hit_valid = 1'b0;
            hit.hit_node = '0;
            hit.occupancy = OCC_EMPTY;
            hit.distance_guess = DIST_NOT_FOUND;
         end
         return clean;
      endfunction

      function void take_word(lookup_word_type w);
         result_type hit;
         bit         clean;
         if (w.op == OP_WRITE) begin
            min_dist[w.slot] = w.min_d;
            max_dist[w.slot] = w.max_d;
            child_mask[w.slot] = w.mask;
            first_child[w.slot] = w.child;
            loaded[w.slot] = 1;
            writes++;
         end else begin
            clean = locate(w.point, hit);
            hits_due.insert(hits_due.size(), hit);
            queries++;
            if (!hit.hit_valid) misses++;
            else class_seen[hit.occupancy]++;
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (hits_due.size() == 0) begin
            $error("response with no query outstanding");
            errors++;
            return;
         end
         want = hits_due.pop_front();
         if (got.hit_valid !== want.hit_valid) begin
            $error("hit_valid: expected %0d, got %0d", want.hit_valid, got.hit_valid);
            errors++;
         end
         if (got.hit_node !== want.hit_node) begin
            $error("hit_node: expected %0d, got %0d", want.hit_node, got.hit_node);
            errors++;
         end
         if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            errors++;
         end
         if (got.distance_guess !== want.distance_guess) begin
            $error("distance_guess: expected %h, got %h", want.distance_guess,
                   got.distance_guess);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_operation = OP_WRITE;
   logic [ADDR_W-1:0] req_node_slot = '0;
   logic [DATA_W-1:0] req_entry_min_dist = '0;
   logic [DATA_W-1:0] req_entry_max_dist = '0;
   logic [MASK_W-1:0] req_entry_mask = '0;
   logic [ADDR_W-1:0] req_entry_first_child = '0;
   logic [DATA_W-1:0] req_point_x = '0;
   logic [DATA_W-1:0] req_point_y = '0;
   logic [DATA_W-1:0] req_point_z = '0;
   logic              rsp_valid;
   logic              rsp_hit_valid;
   logic [ADDR_W-1:0] rsp_hit_node;
   logic [1:0]        rsp_occupancy;
   logic [DATA_W-1:0] rsp_distance_guess;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   lookup_mirror sb = new();
   int           burst_left = 0;
   int           settings = 0;

   always #6 clock = ~clock;

   octree_point_occupancy_lookup_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_node_slot         (req_node_slot),
      .req_entry_min_dist    (req_entry_min_dist),
      .req_entry_max_dist    (req_entry_max_dist),
      .req_entry_mask        (req_entry_mask),
      .req_entry_first_child (req_entry_first_child),
      .req_point_x           (req_point_x),
      .req_point_y           (req_point_y),
      .req_point_z           (req_point_z),
      .rsp_valid             (rsp_valid),
      .rsp_hit_valid         (rsp_hit_valid),
      .rsp_hit_node          (rsp_hit_node),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_distance_guess    (rsp_distance_guess),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(result_type'{rsp_hit_valid, rsp_hit_node, rsp_occupancy,
                                        rsp_distance_guess});
   end

   task automatic issue(input lookup_word_type w);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 4);
         if ($urandom_range(0, 30) == 0) burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= w.op;
      req_node_slot <= w.slot;
      req_entry_min_dist <= w.min_d;
      req_entry_max_dist <= w.max_d;
      req_entry_mask <= w.mask;
      req_entry_first_child <= w.child;
      req_point_x <= w.point[0];
      req_point_y <= w.point[1];
      req_point_z <= w.point[2];
      do @(posedge clock); while (busy);
      sb.take_word(w);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (sb.hits_due.size() > 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic put_reg(input bit [CSR_W-1:0] index, input bit [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(index, data);
   endtask

   task automatic configure(input bit [2:0][DATA_W-1:0] lo, input bit [2:0][DATA_W-1:0] hi,
                            input bit [BAND_W-1:0] bnd, input bit [12:0] cnt);
      put_reg(CSR_MIN_X, lo[0]);
      put_reg(CSR_MIN_Y, lo[1]);
      put_reg(CSR_MIN_Z, lo[2]);
      put_reg(CSR_MAX_X, hi[0]);
      put_reg(CSR_MAX_Y, hi[1]);
      put_reg(CSR_MAX_Z, hi[2]);
      put_reg(CSR_BAND, DATA_W'(bnd));
      put_reg(CSR_NODES, DATA_W'(cnt));
      csr_valid <= 1'b0;
      settings++;
   endtask

   function automatic lookup_word_type node_entry(bit [ADDR_W-1:0] slot, bit [DATA_W-1:0] mn,
                                                  bit [DATA_W-1:0] mx, bit [MASK_W-1:0] mask,
                                                  bit [ADDR_W-1:0] child);
      lookup_word_type w;
      w.op = OP_WRITE;
      w.slot = slot;
      w.min_d = mn;
      w.max_d = mx;
      w.mask = mask;
      w.child = child;
      w.point = {$urandom, $urandom, $urandom};
      return w;
   endfunction

   function automatic lookup_word_type point_query(bit [DATA_W-1:0] x, bit [DATA_W-1:0] y,
                                                   bit [DATA_W-1:0] z);
      lookup_word_type w;
      w.op = OP_QUERY;
      w.slot = $urandom;
      w.min_d = $urandom;
      w.max_d = $urandom;
      w.mask = $urandom;
      w.child = $urandom;
      w.point = {z, y, x};
      return w;
   endfunction

   function automatic bit [DATA_W-1:0] pick_dist();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return DATA_W'(sb.band);
         3: return -DATA_W'(sb.band);
         4, 5, 6, 7, 8: return $urandom;
         default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      endcase
   endfunction

   function automatic bit [MASK_W-1:0] pick_mask();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2: return 8'hFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic bit [ADDR_W-1:0] pick_child(int span);
      case ($urandom_range(0, 19))
         0: return $urandom;
         1, 2: return TABLE_DEPTH - 8 + $urandom_range(0, 7);
         default: return $urandom_range(0, span - 1);
      endcase
   endfunction

   function automatic lookup_word_type random_node(bit [ADDR_W-1:0] slot, int span);
      bit [DATA_W-1:0] a, b;
      a = pick_dist();
      b = pick_dist();
      if ($urandom_range(0, 1) && $signed(a) > $signed(b))
         return node_entry(slot, b, a, pick_mask(), pick_child(span));
      return node_entry(slot, a, b, pick_mask(), pick_child(span));
   endfunction

   function automatic bit [DATA_W-1:0] pick_coord(int a);
      longint lo, hi, v;
      lo = $signed(sb.bound_lo[a]);
      hi = $signed(sb.bound_hi[a]);
      case ($urandom_range(0, 9))
         0: return sb.bound_lo[a];
         1: return sb.bound_hi[a];
         2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return $urandom;
         default: begin
            if (hi <= lo) return $urandom;
            v = lo + longint'($urandom) % (hi - lo + 1);
            return v[DATA_W-1:0];
         end
      endcase
   endfunction

   // Only queries whose walk stays on written entries are sent.
   function automatic bit safe_query(output lookup_word_type w);
      result_type hit;
      for (int t = 0; t < 16; t++) begin
         w = point_query(pick_coord(0), pick_coord(1), pick_coord(2));
         if (sb.locate(w.point, hit)) return 1;
      end
      return 0;
   endfunction

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      bit [2:0][DATA_W-1:0] lo, hi;
      bit [BAND_W-1:0]      bnd;
      bit [12:0]            cnt;
      lookup_word_type      w;
      int                   k;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      issue(point_query(32'h0, 32'h0, 32'h0));
      issue(point_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));

      settle();
      configure({3{32'h0}}, {3{32'h1_0000}}, 31'h800, 13'd12);
      issue(node_entry(0, -32'h4000, 32'h4000, 8'hA5, 1));
      issue(node_entry(1, 32'h1000, 32'h2000, 8'h01, 5));
      issue(node_entry(2, -32'h1_0000, -32'h9000, 8'h00, 0));
      issue(node_entry(3, 32'h0, 32'h100, 8'hFF, 9));
      issue(node_entry(4, 32'h3000, 32'h5000, 8'hFF, 4));
      issue(node_entry(5, 32'h100, 32'h200, 8'h00, 0));
      for (int s = 6; s < 9; s++) issue(node_entry(s, 32'h1000, 32'h1000, 8'h00, 0));
      issue(node_entry(9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00, 0));
      issue(node_entry(10, 32'h8000_0000, 32'h8000_0000, 8'h00, 0));
      issue(node_entry(11, -32'h800, 32'h800, 8'h00, 0));
      issue(point_query(32'h1000, 32'h1000, 32'h1000));
      issue(point_query(32'hC000, 32'h1000, 32'h1000));
      issue(point_query(32'h6000, 32'h1000, 32'h1000));
      issue(point_query(32'h1000, 32'hC000, 32'h1000));
      issue(point_query(32'hC000, 32'h1000, 32'hC000));
      issue(point_query(32'h9000, 32'h1000, 32'h9000));
      issue(point_query(32'hC000, 32'h1000, 32'h9000));
      issue(point_query(32'h9000, 32'h6000, 32'h9000));
      issue(point_query(32'h8000, 32'h8000, 32'h8000));
      issue(point_query(32'hF000, 32'hF000, 32'hF000));
      issue(point_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0));

      for (int p = 0; p < 8; p++) begin
         k = $urandom_range(6, 40);
         bnd = $urandom_range(0, 32'h3_0000);
         case ($urandom_range(0, 2))
            0: cnt = k;
            1: cnt = k + $urandom_range(1, 8);
            default: cnt = TABLE_DEPTH;
         endcase
         for (int a = 0; a < 3; a++) begin
            case (p)
               0: begin
                  lo[a] = 32'h8000_0000;
                  hi[a] = 32'h7FFF_FFFF;
               end
               1: begin
                  lo[a] = $urandom_range(1, 1 << 24);
                  hi[a] = -$urandom_range(1, 1 << 24);
               end
               2: begin
                  lo[a] = $urandom;
                  hi[a] = lo[a];
               end
               4: begin
                  lo[a] = $urandom;
                  hi[a] = $urandom;
               end
               default: begin
                  lo[a] = -$urandom_range(0, 1 << 20);
                  hi[a] = $urandom_range(1, 1 << 20);
               end
            endcase
         end
         case (p)
            0: begin
               bnd = '0;
               cnt = TABLE_DEPTH;
            end
            1: bnd = 31'h7FFF_FFFF;
            2: cnt = 1;
            3: cnt = 0;
            default: ;
         endcase
         settle();
         configure(lo, hi, bnd, cnt);
         for (int s = 0; s < k; s++) issue(random_node(s, k));
         for (int s = TABLE_DEPTH - 8; s < TABLE_DEPTH; s++) issue(random_node(s, k));
         for (int n = 0; n < 155; n++) begin
            if ($urandom_range(0, 49) == 0) settle();
            if ($urandom_range(0, 6) == 0)
               issue(random_node($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, k - 1),
                                 k));
            else if (safe_query(w))
               issue(w);
            else
               issue(random_node($urandom_range(0, k - 1), k));
         end
      end

      settle();
      $display("Ran %0d node writes and %0d queries over %0d register settings.",
               sb.writes, sb.queries, settings);
      $display("Queries not found: %0d; located empty/surface/inside: %0d/%0d/%0d.",
               sb.misses, sb.class_seen[OCC_EMPTY], sb.class_seen[OCC_SURFACE],
               sb.class_seen[OCC_INSIDE]);
      if (sb.errors == 0 && sb.hits_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* octree_point_occupancy_lookup_unit.f */
rtl/ocpl_pkg.sv
rtl/ocpl_ram.sv
rtl/ocpl_classify.sv
rtl/ocpl_walker.sv
rtl/octree_point_occupancy_lookup_unit.sv
test/tb_octree_point_occupancy_lookup_unit.sv
